// File: src/chs_pkg.sv
`default_nettype none
package chs_pkg;

  // cluster size limit, one map bit per node
  localparam int MAX_NODES = 32;
  localparam int MAP_IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  // hash pipeline shape: input stage, mix steps, scaling stage
  localparam int MIX_STEPS  = 7;
  localparam int PIPE_DEPTH = MIX_STEPS + 2;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam logic [31:0] GOLDEN = 32'hdeadbeef;

  // request codes
  localparam logic [1:0] REQ_PACKET = 2'd0;
  localparam logic [1:0] REQ_ADD    = 2'd1;
  localparam logic [1:0] REQ_DEL    = 2'd2;

  // connection states
  localparam logic [2:0] CS_NEW           = 3'd0;
  localparam logic [2:0] CS_RELATED       = 3'd3;
  localparam logic [2:0] CS_RELATED_REPLY = 3'd4;

  // hash modes
  localparam logic [1:0] MODE_ADDR      = 2'd0;
  localparam logic [1:0] MODE_ADDR_SP   = 2'd1;
  localparam logic [1:0] MODE_ADDR_PORTS = 2'd2;
  localparam logic [1:0] MODE_NONE      = 2'd3;

  // register indexes
  localparam logic [1:0] REG_HASH_MODE   = 2'd0;
  localparam logic [1:0] REG_HASH_SEED   = 2'd1;
  localparam logic [1:0] REG_TOTAL_NODES = 2'd2;

  typedef enum logic [2:0] {
    KIND_DROP,
    KIND_PASS,
    KIND_HASH,
    KIND_ADD,
    KIND_DEL,
    KIND_BAD
  } kind_t;

  typedef struct packed {
    logic [1:0]  key_sel;
    logic [31:0] hash_seed;
    logic [5:0]  total_nodes;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] node_number;
    logic        has_conntrack;
    logic [2:0]  conn_state;
    logic        is_icmp;
    logic        ports_valid;
    logic [31:0] src_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic        mark;
    logic [15:0] node;
  } meta_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } abc_t;

  typedef struct packed {
    meta_t      meta;
    logic [5:0] scaled;
  } work_t;

  typedef struct packed {
    logic       drop;
    logic       write_mark;
    logic [5:0] node_hash;
    logic       op_error;
  } res_t;

  // one step of the final mix
  function automatic abc_t mix_step(input logic [2:0] step, input abc_t v);
    abc_t r;
    r = v;
    case (step)
      3'd0: r.c = (v.c ^ v.b) - {v.b[17:0], v.b[31:18]};
      3'd1: r.a = (v.a ^ v.c) - {v.c[20:0], v.c[31:21]};
      3'd2: r.b = (v.b ^ v.a) - {v.a[6:0], v.a[31:7]};
      3'd3: r.c = (v.c ^ v.b) - {v.b[15:0], v.b[31:16]};
      3'd4: r.a = (v.a ^ v.c) - {v.c[27:0], v.c[31:28]};
      3'd5: r.b = (v.b ^ v.a) - {v.a[17:0], v.a[31:18]};
      3'd6: r.c = (v.c ^ v.b) - {v.b[7:0], v.b[31:8]};
      default: r = v;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: src/cluster_node_hash_steering.sv
// Cluster node steering by flow hash.
// Input stream (in_*): one item per transfer. in_tuser carries the request
// type (packet, add node, delete node); in_tdata carries the packet fields.
// Output stream (out_*): exactly one result transfer per input transfer, in
// the same order: drop verdict, write_mark, node_hash and op_error.
// Config port (cfg_*): key_sel at 0x0, hash_seed at 0x4, total_nodes at
// 0x8; to be written by the user only while no item is in flight (the block does not enforce this).
// Throughput: one item per cycle while in_tready is high. From input transfer
// to out_tvalid an item passes the hash pipeline (input stage, seven mix
// stages, one scaling multiply), then the queue write and the output register.
// A 4-entry queue sits between the hash pipeline and the node map stage;
// when the receiver stalls, the output register holds its result, the
// queue fills, and in_tready drops once the queue is full with the last
// hash stage occupied. Add and delete requests take effect for every later
// item in stream order.
// Reset (rst_n low, synchronous) empties the pipeline and queue, clears the
// node map and returns key_sel 0, hash_seed 0, total_nodes 1.
`default_nettype none
module cluster_node_hash_steering (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // node_number[15:0], has_conntrack[16], conn_state[19:17], is_icmp[20],
  // ports_valid[21], src_addr[53:22], src_port[69:54], dst_port[85:70]
  input  wire logic [87:0] in_tdata,
  // req_type[1:0]
  input  wire logic [1:0]  in_tuser,
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // drop[0], write_mark[1], node_hash[7:2], op_error[8]
  output logic [15:0]      out_tdata,
  // config port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import chs_pkg::*;

  cfg_t     cfg_r;
  in_item_t in_item;
  logic     q_push;
  work_t    q_din;
  logic     q_full;
  logic     q_pop;
  logic     q_valid;
  work_t    q_dout;
  res_t     res;
  logic     cfg_wr;

  // config registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key_sel     <= MODE_ADDR;
      cfg_r.hash_seed   <= 32'd0;
      cfg_r.total_nodes <= 6'd1;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_HASH_MODE:   cfg_r.key_sel     <= cfg_pwdata[1:0];
        REG_HASH_SEED:   cfg_r.hash_seed   <= cfg_pwdata;
        REG_TOTAL_NODES: cfg_r.total_nodes <= cfg_pwdata[5:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_paddr[3:2])
      REG_HASH_MODE:   cfg_prdata = {30'd0, cfg_r.key_sel};
      REG_HASH_SEED:   cfg_prdata = cfg_r.hash_seed;
      REG_TOTAL_NODES: cfg_prdata = {26'd0, cfg_r.total_nodes};
      default:         cfg_prdata = 32'd0;
    endcase
  end

  // unpack the input transfer
  always_comb begin
    in_item.req_type      = in_tuser;
    in_item.node_number   = in_tdata[15:0];
    in_item.has_conntrack = in_tdata[16];
    in_item.conn_state    = in_tdata[19:17];
    in_item.is_icmp       = in_tdata[20];
    in_item.ports_valid   = in_tdata[21];
    in_item.src_addr      = in_tdata[53:22];
    in_item.src_port      = in_tdata[69:54];
    in_item.dst_port      = in_tdata[85:70];
  end

  chs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .q_push   (q_push),
    .q_data   (q_din),
    .q_full   (q_full)
  );

  chs_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .din       (q_din),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .dout      (q_dout)
  );

  chs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_data    (q_dout),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // pack the result transfer
  assign out_tdata = {7'd0, res.op_error, res.node_hash, res.write_mark, res.drop};

endmodule
`default_nettype wire

// File: src/chs_front.sv
`default_nettype none
module chs_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire chs_pkg::cfg_t   cfg,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire chs_pkg::in_item_t in_item,
  output logic                 q_push,
  output chs_pkg::work_t       q_data,
  input  wire logic            q_full
);
  import chs_pkg::*;

  logic [PIPE_DEPTH-1:0] vld_r;
  meta_t                 meta_r [PIPE_DEPTH];
  abc_t                  abc_r  [MIX_STEPS+1];
  logic [5:0]            scaled_r;
  logic                  adv;

  meta_t       meta_in;
  abc_t        abc_in;
  logic [15:0] sp;
  logic [15:0] dp;
  logic [31:0] h;
  logic [37:0] prod;

  // whole pipe moves unless a finished item cannot enter the queue
  assign adv      = !q_full || !vld_r[PIPE_DEPTH-1];
  assign in_ready = adv;

  // classify the item
  always_comb begin
    meta_in.node = in_item.node_number;
    meta_in.mark = 1'b0;
    case (in_item.req_type)
      REQ_PACKET: begin
        if (!in_item.has_conntrack) begin
          meta_in.kind = KIND_DROP;
        end else if (in_item.is_icmp && (in_item.conn_state == CS_RELATED ||
                                         in_item.conn_state == CS_RELATED_REPLY)) begin
          meta_in.kind = KIND_PASS;
        end else begin
          meta_in.kind = KIND_HASH;
          meta_in.mark = (in_item.conn_state == CS_NEW);
        end
      end
      REQ_ADD: meta_in.kind = KIND_ADD;
      REQ_DEL: meta_in.kind = KIND_DEL;
      default: meta_in.kind = KIND_BAD;
    endcase
  end

  // hash words with the initial values folded in
  always_comb begin
    sp = in_item.ports_valid ? in_item.src_port : 16'd0;
    dp = in_item.ports_valid ? in_item.dst_port : 16'd0;
    abc_in.a = in_item.src_addr + GOLDEN;
    abc_in.b = ((cfg.key_sel == MODE_ADDR_SP || cfg.key_sel == MODE_ADDR_PORTS) ?
                {16'd0, sp} : 32'd0) + GOLDEN;
    abc_in.c = ((cfg.key_sel == MODE_ADDR_PORTS) ? {16'd0, dp} : 32'd0) + cfg.hash_seed;
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_valid};
    end
  end

  // stage zero
  always_ff @(posedge clk) begin
    if (adv) begin
      meta_r[0] <= meta_in;
      abc_r[0]  <= abc_in;
    end
  end

  // one mix step per stage
  for (genvar k = 1; k <= MIX_STEPS; k++) begin : g_mix
    always_ff @(posedge clk) begin
      if (adv) begin
        meta_r[k] <= meta_r[k-1];
        abc_r[k]  <= mix_step(3'(k - 1), abc_r[k-1]);
      end
    end
  end

  // scale the hash to a node offset: high half of hash times total
  assign h    = (cfg.key_sel == MODE_NONE) ? 32'd0 : abc_r[MIX_STEPS].c;
  assign prod = {6'd0, h} * {32'd0, cfg.total_nodes};

  always_ff @(posedge clk) begin
    if (adv) begin
      meta_r[PIPE_DEPTH-1] <= meta_r[MIX_STEPS];
      scaled_r             <= prod[37:32];
    end
  end

  assign q_push        = adv && vld_r[PIPE_DEPTH-1];
  assign q_data.meta   = meta_r[PIPE_DEPTH-1];
  assign q_data.scaled = scaled_r;

endmodule
`default_nettype wire

// File: src/chs_fifo.sv
`default_nettype none
module chs_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire chs_pkg::work_t din,
  output logic                full,
  input  wire logic           pop,
  output logic                not_empty,
  output chs_pkg::work_t      dout
);
  import chs_pkg::*;

  work_t                 mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_PTR_W:0]   count_r;

  assign full      = (count_r == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign dout      = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule
`default_nettype wire

// File: src/chs_back.sv
`default_nettype none
module chs_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire chs_pkg::cfg_t  cfg,
  input  wire logic           q_valid,
  output logic                q_pop,
  input  wire chs_pkg::work_t q_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output chs_pkg::res_t       out_res
);
  import chs_pkg::*;

  logic [MAX_NODES-1:0] map_r;
  logic [MAX_NODES-1:0] map_nxt;
  logic                 out_valid_r;
  res_t                 res_r;
  res_t                 res_nxt;

  logic [5:0]           hnode;
  logic [15:0]          hnode_m1;
  logic [15:0]          rnode_m1;
  logic                 h_in_map;
  logic                 r_in_range;
  logic                 r_exists;
  logic                 h_bit;
  logic                 r_bit;

  assign q_pop = q_valid && (!out_valid_r || out_ready);

  // node lookups for hashed packets and map requests
  always_comb begin
    hnode      = q_data.scaled + 6'd1;
    hnode_m1   = {10'd0, hnode} - 16'd1;
    rnode_m1   = q_data.meta.node - 16'd1;
    h_in_map   = (32'(hnode) <= 32'(MAX_NODES));
    r_in_range = (q_data.meta.node != 16'd0) &&
                 (q_data.meta.node <= {10'd0, cfg.total_nodes});
    r_exists   = (32'(q_data.meta.node) <= 32'(MAX_NODES));
    h_bit      = map_r[hnode_m1[MAP_IDX_W-1:0]];
    r_bit      = map_r[rnode_m1[MAP_IDX_W-1:0]];
  end

  // verdict and map update
  always_comb begin
    res_nxt = '0;
    map_nxt = map_r;
    case (q_data.meta.kind)
      KIND_DROP: res_nxt.drop = 1'b1;
      KIND_PASS: res_nxt = '0;
      KIND_HASH: begin
        res_nxt.node_hash  = hnode;
        res_nxt.write_mark = q_data.meta.mark;
        res_nxt.drop       = !(h_in_map && h_bit);
      end
      KIND_ADD: begin
        if (!r_in_range || !r_exists || r_bit) begin
          res_nxt.op_error = 1'b1;
        end else begin
          map_nxt[rnode_m1[MAP_IDX_W-1:0]] = 1'b1;
        end
      end
      KIND_DEL: begin
        if (!r_in_range || !r_exists || !r_bit) begin
          res_nxt.op_error = 1'b1;
        end else begin
          map_nxt[rnode_m1[MAP_IDX_W-1:0]] = 1'b0;
        end
      end
      default: res_nxt.op_error = 1'b1;
    endcase
  end

  // map and output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        map_r       <= map_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule
`default_nettype wire

// File: src/chs_checker.sv
`default_nettype none
module chs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // nothing comes out right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a request error never comes with a drop verdict
  a_err_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[8] && out_tdata[0]))
    else $error("op_error and drop both set");

  // a mark write always carries a hashed node
  a_mark_node: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> out_tdata[7:2] != 6'd0)
    else $error("mark written without node");

endmodule

bind cluster_node_hash_steering chs_checker u_chs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

// File: sim/tb_cluster_node_hash_steering.sv
`timescale 1ns / 100ps

package steer_tb_pkg;
  import chs_pkg::*;

  // codes the block package leaves unnamed
  localparam logic [1:0] REQ_UNUSED     = 2'd3;
  localparam logic [2:0] CS_ESTABLISHED = 3'd1;
  localparam logic [2:0] CS_EST_REPLY   = 3'd2;
  localparam logic [2:0] CS_OTHER       = 3'd5;
  localparam logic [2:0] CS_SPARE_6     = 3'd6;
  localparam logic [2:0] CS_SPARE_7     = 3'd7;

  // steering predictor plus in-order verdict checker
  class steer_scoreboard;
    logic [1:0]           mode;
    logic [31:0]          seed;
    logic [5:0]           total;
    logic [MAX_NODES-1:0] node_map;
    res_t                 verdicts_due[$];
    int unsigned          errors;

    function new();
      mode     = MODE_ADDR;
      seed     = '0;
      total    = 6'd1;
      node_map = '0;
      errors   = 0;
    endfunction

    function void load_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_HASH_MODE:   mode = value[1:0];
        REG_HASH_SEED:   seed = value;
        REG_TOTAL_NODES: total = value[5:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] rotl(logic [31:0] v, int s);
      return (v << s) | (v >> (32 - s));
    endfunction

    // lookup3 final avalanche, result is the c word
    function logic [31:0] final_mix(logic [31:0] a, logic [31:0] b, logic [31:0] c);
      c = (c ^ b) - rotl(b, 14);
      a = (a ^ c) - rotl(c, 11);
      b = (b ^ a) - rotl(a, 25);
      c = (c ^ b) - rotl(b, 16);
      a = (a ^ c) - rotl(c, 4);
      b = (b ^ a) - rotl(a, 14);
      c = (c ^ b) - rotl(b, 24);
      return c;
    endfunction

    // flow hash scaled onto 1..total
    function logic [5:0] flow_node(logic [31:0] addr, logic [15:0] sp, logic [15:0] dp);
      logic [31:0] h;
      logic [63:0] prod;
      case (mode)
        MODE_ADDR:       h = final_mix(addr + GOLDEN, GOLDEN, seed);
        MODE_ADDR_SP:    h = final_mix(addr + GOLDEN, {16'd0, sp} + GOLDEN, seed);
        MODE_ADDR_PORTS: h = final_mix(addr + GOLDEN, {16'd0, sp} + GOLDEN, {16'd0, dp} + seed);
        default:         h = '0;
      endcase
      prod = {32'd0, h} * {58'd0, total};
      return prod[37:32] + 6'd1;
    endfunction

    // accepted input transfer: work out its verdict
    function void note_input(logic [1:0] req, logic [87:0] d);
      logic [15:0] node;
      logic        ct;
      logic [2:0]  cs;
      logic        icmp;
      logic        pv;
      logic [31:0] addr;
      logic [15:0] sp;
      logic [15:0] dp;
      logic [5:0]  n;
      res_t        r;
      node = d[15:0];
      ct   = d[16];
      cs   = d[19:17];
      icmp = d[20];
      pv   = d[21];
      addr = d[53:22];
      sp   = pv ? d[69:54] : 16'd0;
      dp   = pv ? d[85:70] : 16'd0;
      r    = '0;
      case (req)
        REQ_PACKET: begin
          if (!ct) begin
            r.drop = 1'b1;
          end else if (!(icmp && (cs == CS_RELATED || cs == CS_RELATED_REPLY))) begin
            n = flow_node(addr, sp, dp);
            r.node_hash  = n;
            r.write_mark = (cs == CS_NEW);
            // nodes past the map have no bit and always drop
            r.drop = (n > MAX_NODES) ? 1'b1 : !node_map[n - 1];
          end
        end
        REQ_ADD, REQ_DEL: begin
          if (node == 0 || node > total || node > MAX_NODES) begin
            r.op_error = 1'b1;
          end else if (req == REQ_ADD) begin
            if (node_map[node - 1]) r.op_error = 1'b1;
            else node_map[node - 1] = 1'b1;
          end else begin
            if (!node_map[node - 1]) r.op_error = 1'b1;
            else node_map[node - 1] = 1'b0;
          end
        end
        default: r.op_error = 1'b1;
      endcase
      verdicts_due.push_back(r);
    endfunction

    // accepted result transfer: compare with the oldest verdict
    function void check_result(logic [15:0] d);
      res_t want;
      if (verdicts_due.size() == 0) begin
        $display("%0t: result with nothing pending, expected none, actual %h", $time, d);
        errors++;
        return;
      end
      want = verdicts_due.pop_front();
      if (d[0] !== want.drop) begin
        $display("%0t: drop expected %0d actual %0d", $time, want.drop, d[0]);
        errors++;
      end
      if (d[1] !== want.write_mark) begin
        $display("%0t: write_mark expected %0d actual %0d", $time, want.write_mark, d[1]);
        errors++;
      end
      if (d[7:2] !== want.node_hash) begin
        $display("%0t: node_hash expected %0d actual %0d", $time, want.node_hash, d[7:2]);
        errors++;
      end
      if (d[8] !== want.op_error) begin
        $display("%0t: op_error expected %0d actual %0d", $time, want.op_error, d[8]);
        errors++;
      end
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction
  endclass
endpackage

module tb_cluster_node_hash_steering;
  import chs_pkg::*;
  import steer_tb_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int SETTLE_WAIT  = 12;
  localparam int DRAIN_CYCLES = 20;
  localparam int LONG_HOLD    = 120;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 90;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  // node_number, has_conntrack, conn_state, is_icmp, ports_valid, src_addr,
  // src_port, dst_port
  logic [87:0] in_tdata = '0;
  // req_type
  logic [1:0]  in_tuser = '0;
  logic        out_tready = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  wire         in_tready;
  wire         out_tvalid;
  // drop, write_mark, node_hash, op_error
  wire  [15:0] out_tdata;
  wire  [31:0] cfg_prdata;
  wire         cfg_pready;

  steer_scoreboard sb = new();
  bit          send_gaps = 1'b1;
  bit          recv_gaps = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned quiet_cycles = 0;
  logic [5:0]  cur_total = 6'd1;

  always #4 clk = ~clk;

  cluster_node_hash_steering u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // bus monitors feed the scoreboard
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)
        sb.load_reg(cfg_paddr[3:2], cfg_pwdata);
      if (in_tvalid && in_tready) sb.note_input(in_tuser, in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result receiver with random and one long hold-off
  initial begin : result_sink
    int unsigned hold;
    do @(posedge clk); while (!rst_n);
    forever begin
      hold = recv_gaps ? $urandom_range(0, 6) : 0;
      if (hold_req) begin
        hold_req = 1'b0;
        hold = LONG_HOLD;
      end
      if (hold != 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  function automatic in_item_t make_item(logic [1:0] req, logic [15:0] node, logic ct,
                                         logic [2:0] cs, logic icmp, logic pv,
                                         logic [31:0] addr, logic [15:0] sp,
                                         logic [15:0] dp);
    in_item_t it;
    it.req_type      = req;
    it.node_number   = node;
    it.has_conntrack = ct;
    it.conn_state    = cs;
    it.is_icmp       = icmp;
    it.ports_valid   = pv;
    it.src_addr      = addr;
    it.src_port      = sp;
    it.dst_port      = dp;
    return it;
  endfunction

  // mostly packets, a fair share of node requests, a few unused requests
  function automatic in_item_t random_item(logic [5:0] tot);
    in_item_t    it;
    int unsigned sel;
    int unsigned hi;
    hi = (tot == 0) ? 1 : tot;
    it = make_item(REQ_PACKET, 16'($urandom), $urandom_range(0, 9) != 0,
                   3'($urandom_range(0, 7)), $urandom_range(0, 4) == 0,
                   $urandom_range(0, 4) != 0, $urandom, 16'($urandom), 16'($urandom));
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      it.req_type = (sel < 22) ? REQ_ADD : (sel < 32) ? REQ_DEL : REQ_UNUSED;
      case ($urandom_range(0, 9))
        0:       it.node_number = 16'($urandom);
        1:       it.node_number = 16'd0;
        2:       it.node_number = 16'(hi + 1);
        default: it.node_number = 16'($urandom_range(1, hi));
      endcase
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = send_gaps ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.req_type;
    in_tdata  <= {2'b00, it.dst_port, it.src_port, it.src_addr, it.ports_valid,
                  it.is_icmp, it.conn_state, it.has_conntrack, it.node_number};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_pkt(input logic ct, input logic [2:0] cs, input logic icmp,
                          input logic pv, input logic [31:0] addr,
                          input logic [15:0] sp, input logic [15:0] dp);
    send_item(make_item(REQ_PACKET, 16'($urandom), ct, cs, icmp, pv, addr, sp, dp));
  endtask

  task automatic send_req(input logic [1:0] req, input logic [15:0] node);
    send_item(make_item(req, node, 1'b1, CS_NEW, 1'b0, 1'b1, $urandom, 16'($urandom),
                        16'($urandom)));
  endtask

  // stop offering, wait for all verdicts, then let the pipeline drain
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [1:0] mode, input logic [31:0] seed,
                            input logic [5:0] tot);
    apb_write(REG_HASH_MODE, {30'd0, mode});
    apb_write(REG_HASH_SEED, seed);
    apb_write(REG_TOTAL_NODES, {26'd0, tot});
    cur_total = tot;
  endtask

  initial begin : stimulus
    logic [1:0]  mode;
    logic [31:0] seed;
    logic [5:0]  tot;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: one node, every packet lands on node 1
    send_pkt(1'b1, CS_NEW, 1'b0, 1'b0, 32'h0, 16'h0, 16'h0);
    send_req(REQ_ADD, 16'd1);
    send_req(REQ_ADD, 16'd1);
    send_pkt(1'b1, CS_ESTABLISHED, 1'b0, 1'b1, '1, '1, '1);
    send_pkt(1'b0, CS_NEW, 1'b0, 1'b1, 32'h0a000001, 16'h5000, 16'h0050);
    send_pkt(1'b1, CS_RELATED, 1'b1, 1'b1, 32'hc0a80001, 16'h1234, 16'h4321);
    send_pkt(1'b1, CS_RELATED_REPLY, 1'b1, 1'b0, 32'hc0a80002, 16'hffff, 16'h0);
    send_pkt(1'b1, CS_RELATED, 1'b0, 1'b1, 32'h7f000001, 16'h0, 16'hffff);
    send_pkt(1'b1, CS_SPARE_6, 1'b1, 1'b1, 32'h80000000, 16'h8000, 16'h0001);
    send_pkt(1'b1, CS_SPARE_7, 1'b0, 1'b1, 32'h00000001, 16'h0001, 16'h8000);
    send_pkt(1'b1, CS_OTHER, 1'b1, 1'b1, 32'hdeadbeef, 16'haaaa, 16'h5555);
    send_req(REQ_ADD, 16'd0);
    send_req(REQ_ADD, 16'd2);
    send_req(REQ_ADD, 16'hffff);
    send_req(REQ_DEL, 16'd0);
    send_req(REQ_UNUSED, 16'd1);
    send_req(REQ_DEL, 16'd1);
    send_req(REQ_DEL, 16'd1);
    send_pkt(1'b1, CS_EST_REPLY, 1'b0, 1'b1, 32'h01020304, 16'h0102, 16'h0304);
    settle();

    // no hash and more nodes than the map holds
    set_config(MODE_NONE, 32'h0, 6'd63);
    send_req(REQ_ADD, 16'd1);
    send_pkt(1'b1, CS_NEW, 1'b0, 1'b1, 32'h55aa55aa, 16'h1111, 16'h2222);
    send_req(REQ_ADD, 16'd33);
    send_req(REQ_DEL, 16'd63);
    send_req(REQ_ADD, 16'd32);
    send_req(REQ_DEL, 16'd32);

    // random phases across settings, gap patterns and one long receiver hold
    for (int p = 0; p < PHASES; p++) begin
      settle();
      seed = $urandom;
      case (p)
        0:       begin mode = MODE_ADDR_PORTS; tot = 6'd32; seed = 32'hffffffff; end
        1:       begin mode = MODE_ADDR_SP;    tot = 6'd5;  end
        2:       begin mode = MODE_ADDR;       tot = 6'd63; seed = 32'h0; end
        3:       begin mode = MODE_NONE;       tot = 6'd8;  end
        4:       begin mode = MODE_ADDR_PORTS; tot = 6'd0;  end
        5:       begin mode = MODE_ADDR_PORTS; tot = 6'd1;  end
        6:       begin mode = MODE_ADDR_SP;    tot = 6'd32; end
        default: begin mode = MODE_ADDR_PORTS; tot = 6'd17; end
      endcase
      set_config(mode, seed, tot);
      send_gaps = (p % 3) != 2;
      recv_gaps = (p % 4) != 3;
      if (p == 6) begin
        send_gaps = 1'b0;
        hold_req = 1'b1;
      end
      repeat (PHASE_ITEMS) send_item(random_item(cur_total));
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
